>>> rtl/lsm_pkg.sv
// Shared constants, codes, command/status types and the sector center table.
package lsm_pkg;

  localparam int unsigned MaxPerSector = 64;
  localparam int unsigned NumSectors   = 8;
  localparam int unsigned SecW         = 3;
  localparam int unsigned AngW         = 16;
  localparam int unsigned RangeW       = 16;
  localparam int unsigned HwW          = 13;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 16;

  localparam logic [SecW-1:0]     LastSector    = SecW'(NumSectors - 1);
  localparam logic [RangeW-1:0]   EmptyMedian   = '1;
  localparam logic [AngW-1:0]     RstStartAngle = 16'd0;
  localparam logic [AngW-1:0]     RstAngleStep  = 16'd182;
  localparam logic [RangeW-1:0]   RstMinRange   = 16'd120;
  localparam logic [RangeW-1:0]   RstMaxRange   = 16'd12000;
  localparam logic [HwW-1:0]      RstHalfWidth  = 13'd907;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartAngle = 3'd0,
    CfgAngleStep  = 3'd1,
    CfgMinRange   = 3'd2,
    CfgMaxRange   = 3'd3,
    CfgHalfWidth  = 3'd4
  } cfg_reg_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch sample, step angle
    logic ins;       // store sample into current sector if it matches
    logic cap_cand;  // latch median candidate from RAM
    logic cmp;       // compare RAM word against candidate
    logic emit;      // load output register, clear sector count
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;      // latched sample closes the scan
    logic cnt_zero;  // current sector holds nothing
    logic j_last;    // compare index at last stored element
    logic found;     // candidate has rank count/2
    logic out_free;  // output register can take a result
  } dp_stat_t;

  function automatic logic [AngW-1:0] sector_center(input logic [SecW-1:0] s);
    logic [AngW-1:0] c;
    case (s)
      3'd0:    c = 16'd32768;
      3'd1:    c = 16'd0;
      3'd2:    c = 16'd49152;
      3'd3:    c = 16'd16384;
      3'd4:    c = 16'd40960;
      3'd5:    c = 16'd24576;
      3'd6:    c = 16'd57344;
      default: c = 16'd8192;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/lsm_in_if.sv
// Sample request channel.
interface lsm_in_if;
  logic                         valid;
  logic                         ready;
  logic [lsm_pkg::RangeW-1:0]   range_mm;
  logic                         sample_bad;
  logic                         last_sample;

  modport source (output valid, range_mm, sample_bad, last_sample, input ready);
  modport sink   (input valid, range_mm, sample_bad, last_sample, output ready);
endinterface

>>> rtl/lsm_out_if.sv
// Sector result channel.
interface lsm_out_if;
  logic                         valid;
  logic                         ready;
  logic [lsm_pkg::SecW-1:0]     sector_id;
  logic [lsm_pkg::RangeW-1:0]   median_mm;
  logic                         sector_empty;
  logic                         last_result;

  modport source (output valid, sector_id, median_mm, sector_empty, last_result, input ready);
  modport sink   (input valid, sector_id, median_mm, sector_empty, last_result, output ready);
endinterface

>>> rtl/lsm_ram.sv
// Generic single-port-write, registered-read RAM.
module lsm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/lsm_dp.sv
// Datapath: config registers, angle tracking, sector stores, rank selection, output register.
module lsm_dp #(
  parameter int unsigned MaxPerSector = lsm_pkg::MaxPerSector,
  localparam int unsigned IdxW = $clog2(MaxPerSector),
  localparam int unsigned CntW = $clog2(MaxPerSector + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lsm_pkg::dp_cmd_t              cmd_i,
  input  logic [lsm_pkg::SecW-1:0]      sec_i,
  input  logic [IdxW-1:0]               rd_idx_i,
  input  logic [IdxW-1:0]               j_i,
  output lsm_pkg::dp_stat_t             stat_o,
  input  logic                          cfg_we_i,
  input  logic [lsm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lsm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [lsm_pkg::RangeW-1:0]    range_i,
  input  logic                          bad_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lsm_pkg::SecW-1:0]      out_sec_o,
  output logic [lsm_pkg::RangeW-1:0]    out_median_o,
  output logic                          out_empty_o,
  output logic                          out_last_o
);
  localparam int unsigned AddrW = lsm_pkg::SecW + IdxW;
  localparam int unsigned Depth = lsm_pkg::NumSectors << IdxW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxPerSector);

  logic [lsm_pkg::AngW-1:0]   start_q, step_q;
  logic [lsm_pkg::RangeW-1:0] min_q, max_q;
  logic [lsm_pkg::HwW-1:0]    hw_q;

  logic [lsm_pkg::AngW-1:0]   cur_q, ang_q, ang_d;
  logic                       active_q;
  logic [lsm_pkg::RangeW-1:0] rng_q;
  logic                       ok_q, last_q;

  logic [CntW-1:0] cnt_q [lsm_pkg::NumSectors];
  logic [CntW-1:0] cnt;
  logic [lsm_pkg::RangeW-1:0] cand_q, rdata;
  logic [CntW-1:0] less_q, leq_q, k;

  logic [lsm_pkg::AngW-1:0] ang_diff, mag;
  logic hit;

  logic                       ov_q;
  logic [lsm_pkg::SecW-1:0]   osec_q;
  logic [lsm_pkg::RangeW-1:0] omed_q;
  logic                       oempty_q, olast_q;

  assign cnt      = cnt_q[sec_i];
  assign k        = cnt >> 1;
  assign ang_d    = active_q ? cur_q : start_q;
  assign ang_diff = ang_q - lsm_pkg::sector_center(sec_i);
  assign mag      = ang_diff[lsm_pkg::AngW-1] ? (~ang_diff + 1'b1) : ang_diff;
  assign hit      = ok_q && (mag <= {3'b000, hw_q}) && (cnt < MaxCnt);

  lsm_ram #(.Width(lsm_pkg::RangeW), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ins && hit),
    .waddr_i ({sec_i, cnt[IdxW-1:0]}),
    .wdata_i (rng_q),
    .raddr_i (AddrW'({sec_i, rd_idx_i})),
    .rdata_o (rdata)
  );

  assign stat_o.last     = last_q;
  assign stat_o.cnt_zero = (cnt == '0);
  assign stat_o.j_last   = (CntW'(j_i) == CntW'(cnt - 1'b1));
  assign stat_o.found    = (less_q <= k) && (k < leq_q);
  assign stat_o.out_free = !ov_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= lsm_pkg::RstStartAngle;
      step_q   <= lsm_pkg::RstAngleStep;
      min_q    <= lsm_pkg::RstMinRange;
      max_q    <= lsm_pkg::RstMaxRange;
      hw_q     <= lsm_pkg::RstHalfWidth;
      cur_q    <= '0;
      active_q <= 1'b0;
      ov_q     <= 1'b0;
      for (int s = 0; s < lsm_pkg::NumSectors; s++) begin
        cnt_q[s] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lsm_pkg::CfgStartAngle: start_q <= cfg_data_i;
          lsm_pkg::CfgAngleStep:  step_q  <= cfg_data_i;
          lsm_pkg::CfgMinRange:   min_q   <= cfg_data_i;
          lsm_pkg::CfgMaxRange:   max_q   <= cfg_data_i;
          lsm_pkg::CfgHalfWidth:  hw_q    <= cfg_data_i[lsm_pkg::HwW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        cur_q    <= ang_d + step_q;
        active_q <= !last_i;
      end
      if (cmd_i.ins && hit) begin
        cnt_q[sec_i] <= cnt + 1'b1;
      end
      if (cmd_i.emit) begin
        cnt_q[sec_i] <= '0;
        ov_q         <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ang_q  <= ang_d;
      rng_q  <= range_i;
      ok_q   <= !bad_i && (range_i >= min_q) && (range_i <= max_q);
      last_q <= last_i;
    end
    if (cmd_i.cap_cand) begin
      cand_q <= rdata;
      less_q <= '0;
      leq_q  <= '0;
    end
    if (cmd_i.cmp) begin
      if (rdata < cand_q)  less_q <= less_q + 1'b1;
      if (rdata <= cand_q) leq_q  <= leq_q + 1'b1;
    end
    if (cmd_i.emit) begin
      osec_q   <= sec_i;
      oempty_q <= (cnt == '0);
      omed_q   <= (cnt == '0) ? lsm_pkg::EmptyMedian : cand_q;
      olast_q  <= (sec_i == lsm_pkg::LastSector);
    end
  end

  assign out_valid_o  = ov_q;
  assign out_sec_o    = osec_q;
  assign out_median_o = omed_q;
  assign out_empty_o  = oempty_q;
  assign out_last_o   = olast_q;
endmodule

>>> rtl/lsm_ctrl.sv
// Controller: sector insertion sweep and per-sector median rank search.
module lsm_ctrl #(
  parameter int unsigned MaxPerSector = lsm_pkg::MaxPerSector,
  localparam int unsigned IdxW = $clog2(MaxPerSector)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  lsm_pkg::dp_stat_t        stat_i,
  output lsm_pkg::dp_cmd_t         cmd_o,
  output logic [lsm_pkg::SecW-1:0] sec_o,
  output logic [IdxW-1:0]          rd_idx_o,
  output logic [IdxW-1:0]          j_o
);
  typedef enum logic [2:0] {
    StIdle, StIns, StSelStart, StRdCand, StCapCand, StCmp, StChk, StEmit
  } state_e;

  state_e state_q, state_d;
  logic [lsm_pkg::SecW-1:0] sec_q, sec_d;
  logic [IdxW-1:0] i_q, i_d, j_q, j_d;
  logic accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign sec_o      = sec_q;
  assign j_o        = j_q;

  always_comb begin
    state_d  = state_q;
    sec_d    = sec_q;
    i_d      = i_q;
    j_d      = j_q;
    cmd_o    = '0;
    rd_idx_o = i_q;
    unique case (state_q)
      StIdle: begin
        cmd_o.load = accept;
        if (accept) begin
          sec_d   = '0;
          state_d = StIns;
        end
      end
      StIns: begin
        cmd_o.ins = 1'b1;
        sec_d     = sec_q + 1'b1;
        if (sec_q == lsm_pkg::LastSector) begin
          sec_d   = '0;
          state_d = stat_i.last ? StSelStart : StIdle;
        end
      end
      StSelStart: begin
        i_d     = '0;
        state_d = stat_i.cnt_zero ? StEmit : StRdCand;
      end
      StRdCand: begin
        rd_idx_o = i_q;
        state_d  = StCapCand;
      end
      StCapCand: begin
        cmd_o.cap_cand = 1'b1;
        rd_idx_o       = '0;
        j_d            = '0;
        state_d        = StCmp;
      end
      StCmp: begin
        // read of j+1 overlaps the compare of j
        cmd_o.cmp = 1'b1;
        rd_idx_o  = j_q + 1'b1;
        j_d       = j_q + 1'b1;
        if (stat_i.j_last) state_d = StChk;
      end
      StChk: begin
        if (stat_i.found) begin
          state_d = StEmit;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = StRdCand;
        end
      end
      StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          sec_d      = sec_q + 1'b1;
          state_d    = (sec_q == lsm_pkg::LastSector) ? StIdle : StSelStart;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sec_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end
endmodule

>>> rtl/lidar_sector_median_core.sv
// Top level: lidar angular sector median filter.
// Each sample is latched, then a sweep over the sectors writes it into every matching store.
// On the last sample each sector then searches its n stored values for the median
// (per candidate: read, capture, n compares, check), plus a select and an emit step per sector.
// Results leave through an output register; the next sample waits for the scan end.
// Reset is asynchronous: config returns to defaults, sector counts clear, RAM is not cleared.
module lidar_sector_median_core #(
  parameter int unsigned MaxPerSector = lsm_pkg::MaxPerSector,
  localparam int unsigned IdxW = $clog2(MaxPerSector)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lsm_in_if.sink                        in_req,
  lsm_out_if.source                     out_res,
  input  logic                          cfg_we_i,
  input  logic [lsm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lsm_pkg::CfgDataW-1:0]  cfg_data_i
);
  lsm_pkg::dp_cmd_t  cmd;
  lsm_pkg::dp_stat_t stat;
  logic [lsm_pkg::SecW-1:0] sec;
  logic [IdxW-1:0] rd_idx, j;
  logic in_ready;

  assign in_req.ready = in_ready;

  lsm_ctrl #(.MaxPerSector(MaxPerSector)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_req.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .sec_o      (sec),
    .rd_idx_o   (rd_idx),
    .j_o        (j)
  );

  lsm_dp #(.MaxPerSector(MaxPerSector)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sec_i        (sec),
    .rd_idx_i     (rd_idx),
    .j_i          (j),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .range_i      (in_req.range_mm),
    .bad_i        (in_req.sample_bad),
    .last_i       (in_req.last_sample),
    .out_valid_o  (out_res.valid),
    .out_ready_i  (out_res.ready),
    .out_sec_o    (out_res.sector_id),
    .out_median_o (out_res.median_mm),
    .out_empty_o  (out_res.sector_empty),
    .out_last_o   (out_res.last_result)
  );
endmodule

>>> tb/sv/tb_lidar_sector_median_core.sv
// Self-checking testbench for lidar_sector_median_core: sector median prediction per scan.
`timescale 1ns / 1ps

module tb_lidar_sector_median_core;
  import lsm_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;

  typedef struct {
    logic [SecW-1:0]   sid;
    logic [RangeW-1:0] median;
    logic              empty;
    logic              last;
  } sector_res_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  lsm_in_if  in_req ();
  lsm_out_if out_res ();

  lidar_sector_median_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req     (in_req.sink),
    .out_res    (out_res.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow of the block's registers and sector stores
  logic [AngW-1:0]   m_start, m_step, m_angle;
  logic [RangeW-1:0] m_min, m_max;
  logic [HwW-1:0]    m_hw;
  logic              m_scan_on;
  logic [RangeW-1:0] sector_vals [NumSectors][$];
  logic [AngW-1:0]   centers [NumSectors] = '{16'd32768, 16'd0, 16'd49152, 16'd16384,
                                              16'd40960, 16'd24576, 16'd57344, 16'd8192};

  sector_res_t medians_q [$];
  int unsigned n_errors;
  int unsigned cycles;
  int unsigned burst_left;
  int unsigned hold_cycles;
  int unsigned stall_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic bit angle_hits(input logic [AngW-1:0] ang, input int s);
    logic [AngW-1:0] d;
    int unsigned mag;
    d = ang - centers[s];
    mag = d[AngW-1] ? 65536 - d : d;
    return mag <= m_hw;
  endfunction

  function automatic void predict_sample(input logic [RangeW-1:0] rng, input logic bad,
                                         input logic last);
    logic [AngW-1:0] ang;
    sector_res_t r;
    int i;
    if (!m_scan_on) begin
      m_angle = m_start;
      m_scan_on = 1'b1;
    end
    ang = m_angle;
    m_angle = m_angle + m_step;
    if (!bad && rng >= m_min && rng <= m_max) begin
      for (int s = 0; s < NumSectors; s++) begin
        if (angle_hits(ang, s) && sector_vals[s].size() < MaxPerSector) begin
          i = 0;
          while (i < sector_vals[s].size() && sector_vals[s][i] <= rng) i++;
          sector_vals[s].insert(i, rng);
        end
      end
    end
    if (last) begin
      for (int s = 0; s < NumSectors; s++) begin
        r.sid = SecW'(s);
        r.empty = sector_vals[s].size() == 0;
        r.median = r.empty ? EmptyMedian : sector_vals[s][sector_vals[s].size() / 2];
        r.last = s == NumSectors - 1;
        medians_q.insert(medians_q.size(), r);
        sector_vals[s].delete();
      end
      m_scan_on = 1'b0;
    end
  endfunction

  task automatic send_sample(input logic [RangeW-1:0] rng, input logic bad, input logic last);
    if (burst_left == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_req.valid       <= 1'b1;
    in_req.range_mm    <= rng;
    in_req.sample_bad  <= bad;
    in_req.last_sample <= last;
    do @(negedge clk_i); while (!in_req.ready);
    @(posedge clk_i);
    predict_sample(rng, bad, last);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgStartAngle: m_start = data;
      CfgAngleStep:  m_step = data;
      CfgMinRange:   m_min = data;
      CfgMaxRange:   m_max = data;
      CfgHalfWidth:  m_hw = data[HwW-1:0];
      default: ;
    endcase
  endtask

  // drop valid, wait for all results, then let the block settle before reconfiguring
  task automatic wait_idle();
    in_req.valid <= 1'b0;
    cfg_we_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (medians_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_all(input logic [15:0] sa, input logic [15:0] st, input logic [15:0] mn,
                         input logic [15:0] mx, input logic [15:0] hw);
    wait_idle();
    cfg_write(CfgStartAngle, sa);
    cfg_write(CfgAngleStep, st);
    cfg_write(CfgMinRange, mn);
    cfg_write(CfgMaxRange, mx);
    cfg_write(CfgHalfWidth, hw);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed_defaults();
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(16'd65535, 1'b0, 1'b0);
    send_sample(16'd120, 1'b0, 1'b0);
    send_sample(16'd119, 1'b0, 1'b0);
    send_sample(16'd12000, 1'b0, 1'b0);
    send_sample(16'd12001, 1'b0, 1'b0);
    send_sample(16'd500, 1'b1, 1'b0);
    send_sample(16'd700, 1'b0, 1'b1);
    send_sample(16'd800, 1'b0, 1'b1);  // single-sample scan
  endtask

  task automatic test_extreme_config();
    // full-turn limits, widest sectors, step wraps near a full turn
    set_all(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd8191);
    for (int i = 0; i < 6; i++) send_sample(16'($urandom), 1'b0, i == 5);
    set_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'd0, 1'b0, 1'b0);
    send_sample(16'd1, 1'b0, 1'b1);
    // inverted limits drop everything
    set_all(16'd32768, 16'd16384, 16'hFFFF, 16'd0, 16'd907);
    for (int i = 0; i < 4; i++) send_sample(16'($urandom), 1'b0, i == 3);
  endtask

  task automatic test_unknown_index();
    wait_idle();
    cfg_write(cfg_reg_e'(3'd5), 16'd1);
    cfg_write(cfg_reg_e'(3'd6), 16'd2);
    cfg_write(cfg_reg_e'(3'd7), 16'd3);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    for (int i = 0; i < 4; i++) send_sample(16'(1000 + i), 1'b0, i == 3);
  endtask

  task automatic test_full_sector();
    // zero step pins every sample onto one sector; overflow must be dropped
    set_all(16'd8192, 16'd0, 16'd0, 16'hFFFF, 16'd8191);
    for (int i = 0; i < 70; i++) send_sample(16'($urandom), 1'b0, i == 69);
  endtask

  task automatic test_pressure();
    set_all(16'd0, 16'd4096, 16'd0, 16'hFFFF, 16'd2048);
    hold_cycles = 600;
    for (int k = 0; k < 2; k++)
      for (int i = 0; i < 10; i++) send_sample(16'($urandom), $urandom_range(0, 7) == 0, i == 9);
  endtask

  task automatic test_random();
    int sent;
    int len;
    sent = 0;
    while (sent < 40) begin
      set_all(16'($urandom), ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192)),
              16'($urandom_range(0, 2000)),
              ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(3000, 65535)),
              16'($urandom_range(0, 8191)));
      for (int g = 0; g < 3; g++) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
          send_sample(16'($urandom), $urandom_range(0, 9) == 0, i == len - 1);
        sent += len;
      end
    end
  endtask

  // receiver: random short stalls plus an optional long hold-off
  initial begin
    out_res.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_res.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_res.ready <= 1'b0;
        stall_left--;
      end else begin
        out_res.ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 6);
      end
    end
  end

  // result check; ready and the payload are stable at the falling edge
  initial begin
    sector_res_t e;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_res.valid && out_res.ready) begin
        if (medians_q.size() == 0) begin
          $error("unexpected result: sector_id %0d", out_res.sector_id);
          n_errors++;
        end else begin
          e = medians_q.pop_front();
          if (out_res.sector_id !== e.sid) begin
            $error("sector_id: exp %0d got %0d", e.sid, out_res.sector_id);
            n_errors++;
          end
          if (out_res.median_mm !== e.median) begin
            $error("median_mm: exp %0d got %0d", e.median, out_res.median_mm);
            n_errors++;
          end
          if (out_res.sector_empty !== e.empty) begin
            $error("sector_empty: exp %0d got %0d", e.empty, out_res.sector_empty);
            n_errors++;
          end
          if (out_res.last_result !== e.last) begin
            $error("last_result: exp %0d got %0d", e.last, out_res.last_result);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_req.valid = 1'b0;
    in_req.range_mm = '0;
    in_req.sample_bad = 1'b0;
    in_req.last_sample = 1'b0;
    n_errors = 0;
    cycles = 0;
    burst_left = 0;
    hold_cycles = 0;
    stall_left = 0;
    m_start = RstStartAngle;
    m_step = RstAngleStep;
    m_min = RstMinRange;
    m_max = RstMaxRange;
    m_hw = RstHalfWidth;
    m_angle = '0;
    m_scan_on = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_defaults();
    test_extreme_config();
    test_unknown_index();
    test_full_sector();
    test_pressure();
    test_random();
    wait_idle();

    if (n_errors == 0 && medians_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> lidar_sector_median_core.f
rtl/lsm_pkg.sv
rtl/lsm_in_if.sv
rtl/lsm_out_if.sv
rtl/lsm_ram.sv
rtl/lsm_dp.sv
rtl/lsm_ctrl.sv
rtl/lidar_sector_median_core.sv
tb/sv/tb_lidar_sector_median_core.sv
